[rtl/cuwt_pkg.sv]
// Shared types and constants for the card identifier whitelist table.
package cuwt_pkg;

  localparam int LEN_W = 4;
  localparam int OUT_CNT_W = 5;

  localparam logic [1:0] CMD_VERIFY = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic        tag_is_type4a;
    logic [3:0]  uid_size;
    logic [63:0] uid_low;
    logic [15:0] uid_high;
  } req_t;

  typedef struct packed {
    logic                 success;
    logic [OUT_CNT_W-1:0] entry_count;
  } rsp_t;

  // search token walking the cell chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

  // table update strobes, valid for one cycle
  typedef struct packed {
    logic add_en;
    logic del_en;
  } ctl_t;

endpackage

[rtl/cuwt_cell.sv]
// One table entry: stored identifier, match check and shift-down path.
module cuwt_cell
  import cuwt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int KEY_W = 80,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] key,
  input  logic [LEN_W-1:0] key_len,
  input  ctl_t             ctl,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  logic [KEY_W-1:0] up_uid,
  input  logic [LEN_W-1:0] up_len,
  output logic [KEY_W-1:0] uid,
  output logic [LEN_W-1:0] len
);

  logic occupied;
  logic keep_next;
  logic match;
  logic at_or_after_hit;

  assign occupied  = CNT_W'(IDX) < count;
  assign keep_next = CNT_W'(IDX + 1) < count;
  // bytes past the length are held at zero, so a full compare suffices
  assign match     = occupied && (len == key_len) && (uid == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out         <= '0;
      at_or_after_hit <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | match;
      if (tok_in.valid) begin
        at_or_after_hit <= tok_in.found | match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add_en && (CNT_W'(IDX) == count)) begin
      uid <= key;
      len <= key_len;
    end else if (ctl.del_en && at_or_after_hit && keep_next) begin
      uid <= up_uid;
      len <= up_len;
    end
  end

endmodule

[rtl/card_uid_whitelist_table.sv]
// Top level of the card identifier whitelist table: controller and cell chain.
//
// Requests enter on req (req_valid / req_stall), one card read and a command
// each: verify, add or delete. Every request yields exactly one response on
// rsp (rsp_valid / rsp_stall) carrying a success flag and the entry count.
// The table is a row of TABLE_DEPTH cells, one entry each. A search token
// walks the row one cell per cycle; the update (append or shift-down of all
// later entries) follows the search. A new request is taken only after the
// previous one has been applied; req_stall is high while a request is in
// the search or update phase.
// The response sits in an output register, so the next request is accepted
// while a response still waits; if rsp_stall holds the register full when
// the next update is ready, that update waits until the register is taken.
// Reset empties the table (count zero) and clears all pending work; stored
// identifiers are not cleared and are never read past the count.
module card_uid_whitelist_table
  import cuwt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int UID_BYTES   = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int KEY_W = UID_BYTES * 8;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_APPLY} state_t;

  state_t           state;
  logic [1:0]       cmd;
  logic             type4a;
  logic [KEY_W-1:0] key;
  logic [LEN_W-1:0] key_len;
  logic [CNT_W-1:0] count;
  logic             head_valid;
  logic             found;

  logic [79:0]      raw_uid;
  logic [LEN_W-1:0] len_next;
  logic [KEY_W-1:0] key_next;
  logic             accept;
  logic             apply_go;
  logic             ok;
  logic [CNT_W-1:0] count_next;
  ctl_t             ctl;

  tok_t             tok [0:TABLE_DEPTH];
  logic [KEY_W-1:0] uid_q [0:TABLE_DEPTH-1];
  logic [LEN_W-1:0] len_q [0:TABLE_DEPTH-1];

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign raw_uid   = {req.uid_high, req.uid_low};
  assign len_next  = (req.uid_size > LEN_W'(UID_BYTES)) ? LEN_W'(UID_BYTES) : req.uid_size;

  always_comb begin
    for (int b = 0; b < UID_BYTES; b++) begin
      key_next[8*b +: 8] = (LEN_W'(b) < len_next) ? raw_uid[8*b +: 8] : 8'd0;
    end
  end

  assign apply_go = (state == S_APPLY) && (!rsp_valid || !rsp_stall);

  always_comb begin
    ok         = 1'b0;
    ctl        = '0;
    count_next = count;
    unique case (cmd)
      CMD_VERIFY: ok = type4a && found;
      CMD_ADD: begin
        ok         = (count < CNT_W'(TABLE_DEPTH)) && type4a && !found;
        ctl.add_en = apply_go && ok;
        if (ok) count_next = count + CNT_W'(1);
      end
      CMD_DELETE: begin
        ok         = type4a && found;
        ctl.del_en = apply_go && ok;
        if (ok) count_next = count - CNT_W'(1);
      end
      default: ok = 1'b0;
    endcase
  end

  assign tok[0] = '{valid: head_valid, found: 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      head_valid <= accept;
      rsp_valid  <= apply_go || (rsp_valid && rsp_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd        <= req.command;
            type4a     <= req.tag_is_type4a;
            key        <= key_next;
            key_len    <= len_next;
            state      <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tok[TABLE_DEPTH].valid) begin
            found <= tok[TABLE_DEPTH].found;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            count           <= count_next;
            rsp.success     <= ok;
            rsp.entry_count <= OUT_CNT_W'(count_next);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] up_uid;
    logic [LEN_W-1:0] up_len;
    if (i < TABLE_DEPTH - 1) begin : g_up
      assign up_uid = uid_q[i+1];
      assign up_len = len_q[i+1];
    end else begin : g_top
      assign up_uid = uid_q[i];
      assign up_len = len_q[i];
    end
    cuwt_cell #(
      .IDX   (i),
      .KEY_W (KEY_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .key     (key),
      .key_len (key_len),
      .ctl     (ctl),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .up_uid  (up_uid),
      .up_len  (up_len),
      .uid     (uid_q[i]),
      .len     (len_q[i])
    );
  end

endmodule

[test/tb_card_uid_whitelist_table.sv]
// Self-checking testbench for the card UID whitelist table: directed table, random reads.
module tb_card_uid_whitelist_table;
  import cuwt_pkg::*;

  localparam int DEPTH = 16;
  localparam int UID_N = 10;
  localparam int LIMIT = 300000;
  localparam int PHASE_READS = 475;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int IDLE_PCT [4] = '{0, 80, 0, 30};
  localparam int STALL_PCT [4] = '{0, 0, 80, 30};

  typedef struct packed {
    logic [1:0]  cmd;
    logic        t4;
    logic [3:0]  sz;
    logic [63:0] lo;
    logic [15:0] hi;
    logic        typed;
    logic        ok;
    logic [4:0]  cnt;
    logic [3:0]  rpt;
  } step_t;

  // typed rows carry their answer; rpt adds copies with lo + 1, lo + 2, ...
  localparam step_t PLAN [25] = '{
    '{CMD_VERIFY, 1, 4, 64'h0123_4567_89ab_cdef, 16'h0, 1, 0, 0, 0},
    '{CMD_DELETE, 1, 4, 64'h0123_4567_89ab_cdef, 16'h0, 1, 0, 0, 0},
    '{CMD_ADD, 0, 4, 64'h0123_4567_89ab_cdef, 16'h0, 1, 0, 0, 0},
    '{CMD_ADD, 1, 0, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 1, 1, 0},
    '{CMD_ADD, 1, 10, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 1, 2, 0},
    '{CMD_ADD, 1, 15, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 0, 2, 0},
    '{CMD_VERIFY, 1, 0, 64'h0, 16'h0, 1, 1, 2, 0},
    '{CMD_NONE, 1, 4, 64'h0123_4567_89ab_cdef, 16'h0, 1, 0, 2, 0},
    '{CMD_ADD, 1, 4, 64'h0000_0000_dead_beef, 16'h0, 1, 1, 3, 0},
    '{CMD_VERIFY, 1, 4, 64'hffff_ffff_dead_beef, 16'h1234, 1, 1, 3, 0},
    '{CMD_VERIFY, 1, 5, 64'h0000_0000_dead_beef, 16'h0, 1, 0, 3, 0},
    '{CMD_VERIFY, 0, 4, 64'h0000_0000_dead_beef, 16'h0, 1, 0, 3, 0},
    '{CMD_DELETE, 0, 4, 64'h0000_0000_dead_beef, 16'h0, 1, 0, 3, 0},
    '{CMD_DELETE, 1, 0, 64'h5555_aaaa_5555_aaaa, 16'h5a5a, 1, 1, 2, 0},
    '{CMD_VERIFY, 1, 10, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 1, 2, 0},
    '{CMD_ADD, 1, 7, 64'h0011_2233_4455_6677, 16'h0, 0, 0, 0, 13},
    '{CMD_ADD, 1, 6, 64'h0000_0a0b_0c0d_0e0f, 16'h0, 1, 0, 16, 0},
    '{CMD_ADD, 0, 6, 64'h0000_0a0b_0c0d_0e0f, 16'h0, 1, 0, 16, 0},
    '{CMD_ADD, 1, 10, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 0, 16, 0},
    '{CMD_DELETE, 1, 4, 64'h0000_0000_dead_beef, 16'h0, 1, 1, 15, 0},
    '{CMD_VERIFY, 1, 4, 64'h0000_0000_dead_beef, 16'h0, 1, 0, 15, 0},
    '{CMD_VERIFY, 1, 7, 64'h0011_2233_4455_6684, 16'h0, 0, 0, 0, 0},
    '{CMD_DELETE, 1, 10, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 1, 14, 0},
    '{CMD_VERIFY, 1, 15, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 0, 14, 0},
    '{CMD_NONE, 0, 4, 64'h0000_0000_dead_beef, 16'h0, 1, 0, 14, 0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic [79:0] held_uid [DEPTH];
  int held_len [DEPTH];
  int held_n = 0;
  bit filling = 1'b1;
  rsp_t answer_q [$];

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  card_uid_whitelist_table DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [79:0] byte_mask(int n);
    return {80{1'b1}} >> (80 - 8 * n);
  endfunction

  // applies one request to the table copy and returns its response
  function automatic rsp_t table_apply(req_t r);
    logic [79:0] key;
    int n;
    int hit;
    bit ok;
    rsp_t a;
    n = (r.uid_size > UID_N) ? UID_N : int'(r.uid_size);
    key = {r.uid_high, r.uid_low} & byte_mask(n);
    hit = held_n;
    for (int i = held_n - 1; i >= 0; i--)
      if (held_len[i] == n && held_uid[i] == key) hit = i;
    ok = 1'b0;
    case (r.command)
      CMD_VERIFY: begin
        ok = r.tag_is_type4a && hit < held_n;
      end
      CMD_ADD: begin
        if (held_n < DEPTH && r.tag_is_type4a && hit == held_n) begin
          held_uid[held_n] = key;
          held_len[held_n] = n;
          held_n++;
          ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (r.tag_is_type4a && hit < held_n) begin
          for (int i = hit; i < held_n - 1; i++) begin
            held_uid[i] = held_uid[i + 1];
            held_len[i] = held_len[i + 1];
          end
          held_n--;
          ok = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    a.success = ok;
    a.entry_count = OUT_CNT_W'(held_n);
    return a;
  endfunction

  // mostly reads of stored cards or fresh cards, some near misses and noise
  function automatic req_t make_read();
    req_t r;
    int pick;
    int i;
    int n;
    logic [79:0] id;
    r.uid_low = {$urandom, $urandom};
    r.uid_high = 16'($urandom);
    r.tag_is_type4a = ($urandom_range(99) < 92);
    r.uid_size = 4'($urandom_range(UID_N));
    if (held_n == DEPTH) filling = 1'b0;
    else if (held_n == 0) filling = 1'b1;
    pick = $urandom_range(99);
    if (pick < 15) begin
      r.command = 2'($urandom_range(3));
      r.tag_is_type4a = 1'($urandom_range(1));
      r.uid_size = 4'($urandom_range(15));
      return r;
    end
    pick = $urandom_range(99);
    if (pick < (filling ? 60 : 20)) r.command = CMD_ADD;
    else if (pick < 80) r.command = CMD_DELETE;
    else r.command = CMD_VERIFY;
    if (held_n > 0 && ((r.command != CMD_ADD) ? ($urandom_range(9) < 8)
                                              : ($urandom_range(9) == 0))) begin
      i = $urandom_range(held_n - 1);
      n = held_len[i];
      id = ({r.uid_high, r.uid_low} & ~byte_mask(n)) | held_uid[i];
      if (n == UID_N && $urandom_range(1) == 1) r.uid_size = 4'($urandom_range(15, UID_N));
      else r.uid_size = 4'(n);
      if ($urandom_range(4) == 0) begin
        if (n > 0 && $urandom_range(1) == 1) id = id ^ (80'd1 << $urandom_range(8 * n - 1));
        else r.uid_size = 4'($urandom_range(UID_N));
      end
      {r.uid_high, r.uid_low} = id;
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_read(input req_t r, input bit typed, input rsp_t typed_ans);
    rsp_t a;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    a = table_apply(r);
    answer_q.push_back(typed ? typed_ans : a);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      rsp_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (answer_q.size() == 0) begin
        note_mismatch("response with no request pending, count", rsp.entry_count, -1);
      end else begin
        want = answer_q.pop_front();
        if (rsp.success !== want.success)
          note_mismatch("success", rsp.success, want.success);
        if (rsp.entry_count !== want.entry_count)
          note_mismatch("entry_count", rsp.entry_count, want.entry_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req_t rd;
    rsp_t ans;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    foreach (PLAN[s]) begin
      for (int k = 0; k <= int'(PLAN[s].rpt); k++) begin
        rd = '{PLAN[s].cmd, PLAN[s].t4, PLAN[s].sz, PLAN[s].lo + 64'(k), PLAN[s].hi};
        ans = '{PLAN[s].ok, PLAN[s].cnt};
        offer_read(rd, PLAN[s].typed, ans);
      end
    end
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      if (ph == 0) hold_go = 1'b1;
      repeat (PHASE_READS) offer_read(make_read(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
